### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### design/alie_pkg.sv
// ----------------------------------------------------------------------------
// alie_pkg
// shared widths, command and status codes, and the cell control bundle
// ----------------------------------------------------------------------------
package alie_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int ST_W   = 3;
	localparam int OCNT_W = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_SORT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_ONE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_ALL  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

	// how a cell decides it is the target slot
	typedef enum logic [1:0] {
		HIT_NONE = 2'd0,
		HIT_POS  = 2'd1,
		HIT_LT   = 2'd2,
		HIT_EQ   = 2'd3
	} hit_mode_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic      cmp_en;
		logic      exec_en;
		logic      ins;
		hit_mode_t mode;
	} cell_ctrl_t;

endpackage

### design/alie_if.sv
// ----------------------------------------------------------------------------
// alie_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface alie_req_if;
	logic                                valid;
	logic                                ready;
	logic [alie_pkg::CMD_W-1:0]          cmd;
	logic [alie_pkg::POS_W-1:0]          position;
	logic signed [alie_pkg::DATA_W-1:0]  value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

interface alie_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [alie_pkg::ST_W-1:0]           status;
	logic [alie_pkg::OCNT_W-1:0]         new_count;
	logic [alie_pkg::OCNT_W-1:0]         removed_count;
	logic signed [alie_pkg::DATA_W-1:0]  read_value;

	modport source (output valid, output status, output new_count, output removed_count,
		output read_value, input ready);
	modport sink (input valid, input status, input new_count, input removed_count,
		input read_value, output ready);
endinterface

### design/alie_cell.sv
// ----------------------------------------------------------------------------
// alie_cell
// one list slot: holds an element, compares it with the command value and
// shifts toward or away from its neighbors on an insert or a delete
// ----------------------------------------------------------------------------
module alie_cell #(
	parameter int CAPACITY = 16,
	parameter int IDX      = 0
) (
	input  logic                              clk,
	input  alie_pkg::cell_ctrl_t              ctrl,
	input  logic [$clog2(CAPACITY)-1:0]       k,
	input  logic [$clog2(CAPACITY+1)-1:0]     count,
	input  logic [alie_pkg::DATA_W-1:0]       value,
	input  logic [alie_pkg::DATA_W-1:0]       left_elem,
	input  logic [alie_pkg::DATA_W-1:0]       right_elem,
	input  logic                              chain_in,
	output logic [alie_pkg::DATA_W-1:0]       elem,
	output logic                              chain_out,
	output logic [alie_pkg::DATA_W-1:0]       sel_elem
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);

	logic [alie_pkg::DATA_W-1:0] elem_q;
	logic                        lt_q;
	logic                        eq_q;
	logic                        occupied;
	logic                        at_end;
	logic                        hit;

	// slot position against the fill level
	assign occupied = CNT_W'(IDX) < count;
	assign at_end   = CNT_W'(IDX) == count;

	// target slot for this command
	always_comb begin
		case (ctrl.mode)
			alie_pkg::HIT_POS: hit = IDX_W'(IDX) == k;
			alie_pkg::HIT_LT:  hit = (occupied && !lt_q) || at_end;
			alie_pkg::HIT_EQ:  hit = occupied && eq_q;
			default:           hit = 1'b0;
		endcase
	end

	// earlier hit seen anywhere to the left
	assign chain_out = chain_in | hit;

	// compare flags and element shift
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= $signed(elem_q) < $signed(value);
			eq_q <= elem_q == value;
		end
		if (ctrl.exec_en) begin
			if (ctrl.ins) begin
				if (chain_in) begin
					elem_q <= left_elem;
				end else if (hit) begin
					elem_q <= value;
				end
			end else if (chain_in || hit) begin
				elem_q <= right_elem;
			end
		end
	end

	assign elem     = elem_q;
	assign sel_elem = hit ? elem_q : '0;

endmodule

### design/array_list_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_engine
// packed list of signed words kept in a chain of cells, with positional and
// sorted insert, positional and value delete, delete-all, and read
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | cmd, position, value
//  rsp     | out | valid/ready | status, new_count, removed_count, read_value
//
//  states from the accept up to the result register load:
//  read and commands refused on fill, empty list or position: compare, respond;
//    insert and deletes: compare, execute, respond; delete all adds a pass per match
//  each delete-all pass runs the cell compare register and then one chain shift
//  req is taken only in idle; a result not yet taken holds the engine in respond
//  arst_n clears the count and the control; cell contents are not reset
`include "assert_macros.svh"

module array_list_insert_delete_engine #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	alie_req_if.sink         req,
	alie_rsp_if.source       rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int CW    = ((CNT_W > alie_pkg::POS_W) ? CNT_W : alie_pkg::POS_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CMP   = 5'b00010,
		S_RECMP = 5'b00100,
		S_EXEC  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                         state_q, state_d;
	logic [CNT_W-1:0]               cnt_q, cnt_d;
	logic [CNT_W-1:0]               rm_q, rm_d;
	logic [alie_pkg::ST_W-1:0]      st_q, st_d;
	logic [alie_pkg::DATA_W-1:0]    rd_q, rd_d;
	logic [alie_pkg::CMD_W-1:0]     cmd_q;
	logic [alie_pkg::POS_W-1:0]     pos_q;
	logic [alie_pkg::DATA_W-1:0]    val_q;
	logic                           out_valid_q;
	logic                           load_out;
	logic [alie_pkg::ST_W-1:0]      o_status_q;
	logic [alie_pkg::OCNT_W-1:0]    o_count_q;
	logic [alie_pkg::OCNT_W-1:0]    o_removed_q;
	logic [alie_pkg::DATA_W-1:0]    o_read_q;

	alie_pkg::cell_ctrl_t           ctrl;
	logic [CW-1:0]                  pos_x, cnt_x, k_x;
	logic [IDX_W-1:0]               k;
	logic                           full, empty, ins_bad, del_bad, any_hit;
	logic [alie_pkg::DATA_W-1:0]    rd_or;

	logic [alie_pkg::DATA_W-1:0]    elem_w  [CAPACITY];
	logic [alie_pkg::DATA_W-1:0]    left_w  [CAPACITY];
	logic [alie_pkg::DATA_W-1:0]    right_w [CAPACITY];
	logic [alie_pkg::DATA_W-1:0]    sel_w   [CAPACITY];
	logic [CAPACITY:0]              chain_w;

	// position checks against the current fill level
	assign pos_x   = CW'(pos_q);
	assign cnt_x   = CW'(cnt_q);
	assign k_x     = pos_x - CW'(1);
	assign k       = k_x[IDX_W-1:0];
	assign full    = cnt_q == CNT_W'(CAPACITY);
	assign empty   = cnt_q == '0;
	assign ins_bad = (pos_q == '0) || (pos_x > cnt_x + CW'(1));
	assign del_bad = (pos_q == '0) || (pos_x > cnt_x);

	// cell chain
	assign chain_w[0] = 1'b0;
	assign any_hit    = chain_w[CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_w[g] = '0;
		end else begin : g_mid_l
			assign left_w[g] = elem_w[g-1];
		end
		if (g == CAPACITY-1) begin : g_last
			assign right_w[g] = '0;
		end else begin : g_mid_r
			assign right_w[g] = elem_w[g+1];
		end

		alie_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (g)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.k          (k),
			.count      (cnt_q),
			.value      (val_q),
			.left_elem  (left_w[g]),
			.right_elem (right_w[g]),
			.chain_in   (chain_w[g]),
			.elem       (elem_w[g]),
			.chain_out  (chain_w[g+1]),
			.sel_elem   (sel_w[g])
		);
	end

	// read data: only the addressed cell drives a nonzero word
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | sel_w[i];
		end
	end

	// sequencer
	always_comb begin
		ctrl.cmp_en  = 1'b0;
		ctrl.exec_en = 1'b0;
		ctrl.ins     = (cmd_q == alie_pkg::CMD_INS_POS) || (cmd_q == alie_pkg::CMD_INS_SORT);
		state_d      = state_q;
		cnt_d        = cnt_q;
		rm_d         = rm_q;
		st_d         = st_q;
		rd_d         = rd_q;
		load_out     = 1'b0;
		// hit mode follows the command
		case (cmd_q)
			alie_pkg::CMD_INS_POS,
			alie_pkg::CMD_DEL_POS,
			alie_pkg::CMD_READ:     ctrl.mode = alie_pkg::HIT_POS;
			alie_pkg::CMD_INS_SORT: ctrl.mode = alie_pkg::HIT_LT;
			alie_pkg::CMD_DEL_ONE,
			alie_pkg::CMD_DEL_ALL:  ctrl.mode = alie_pkg::HIT_EQ;
			default:                ctrl.mode = alie_pkg::HIT_NONE;
		endcase
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = S_EXEC;
				case (cmd_q)
					alie_pkg::CMD_INS_POS: begin
						if (full) begin
							st_d    = alie_pkg::ST_FULL;
							state_d = S_RESP;
						end else if (ins_bad) begin
							st_d    = alie_pkg::ST_BADPOS;
							state_d = S_RESP;
						end
					end
					alie_pkg::CMD_INS_SORT: begin
						if (full) begin
							st_d    = alie_pkg::ST_FULL;
							state_d = S_RESP;
						end
					end
					alie_pkg::CMD_DEL_POS: begin
						if (empty) begin
							st_d    = alie_pkg::ST_EMPTY;
							state_d = S_RESP;
						end else if (del_bad) begin
							st_d    = alie_pkg::ST_BADPOS;
							state_d = S_RESP;
						end
					end
					alie_pkg::CMD_DEL_ONE,
					alie_pkg::CMD_DEL_ALL: begin
						if (empty) begin
							st_d    = alie_pkg::ST_EMPTY;
							state_d = S_RESP;
						end
					end
					alie_pkg::CMD_READ: begin
						state_d = S_RESP;
						if (empty) begin
							st_d = alie_pkg::ST_EMPTY;
						end else if (del_bad) begin
							st_d = alie_pkg::ST_BADPOS;
						end else begin
							rd_d = rd_or;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_RECMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
				case (cmd_q)
					alie_pkg::CMD_INS_POS,
					alie_pkg::CMD_INS_SORT: begin
						ctrl.exec_en = 1'b1;
						cnt_d        = cnt_q + CNT_W'(1);
					end
					alie_pkg::CMD_DEL_POS: begin
						ctrl.exec_en = 1'b1;
						cnt_d        = cnt_q - CNT_W'(1);
						rm_d         = CNT_W'(1);
					end
					alie_pkg::CMD_DEL_ONE: begin
						if (any_hit) begin
							ctrl.exec_en = 1'b1;
							cnt_d        = cnt_q - CNT_W'(1);
							rm_d         = CNT_W'(1);
						end else begin
							st_d = alie_pkg::ST_NOTFOUND;
						end
					end
					alie_pkg::CMD_DEL_ALL: begin
						if (any_hit) begin
							ctrl.exec_en = 1'b1;
							cnt_d        = cnt_q - CNT_W'(1);
							rm_d         = rm_q + CNT_W'(1);
							state_d      = S_RECMP;
						end else if (rm_q == '0) begin
							st_d = alie_pkg::ST_NOTFOUND;
						end
					end
					default: begin
					end
				endcase
			end
			S_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req.ready = state_q == S_IDLE;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command beat capture and per-command result
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.cmd;
			pos_q <= req.position;
			val_q <= req.value;
			st_q  <= alie_pkg::ST_OK;
			rm_q  <= '0;
			rd_q  <= '0;
		end else begin
			st_q <= st_d;
			rm_q <= rm_d;
			rd_q <= rd_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			o_status_q  <= st_q;
			o_count_q   <= alie_pkg::OCNT_W'(cnt_q);
			o_removed_q <= alie_pkg::OCNT_W'(rm_q);
			o_read_q    <= rd_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = o_status_q;
	assign rsp.new_count     = o_count_q;
	assign rsp.removed_count = o_removed_q;
	assign rsp.read_value    = o_read_q;

	// checks
	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY))
	`ASSERT_NEXT(a_ins_grows, ctrl.exec_en && ctrl.ins, cnt_q == $past(cnt_q) + CNT_W'(1))
	`ASSERT_NEXT(a_del_shrinks, ctrl.exec_en && !ctrl.ins, cnt_q == $past(cnt_q) - CNT_W'(1))
	`ASSERT_NEXT(a_resp_loads, load_out, out_valid_q && (state_q == S_IDLE))
	`ASSERT_SAME(a_exec_has_hit, ctrl.exec_en, any_hit)

endmodule

### test/tb_array_list_insert_delete_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_engine
// drives list commands into the engine under random sender gaps and receiver
// stalls, predicts every result from a shadow copy of the list, and compares
// each result beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_engine;

	localparam int LIST_CAP     = 16;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 60;
	localparam int CYCLE_LIMIT  = 1000000;

	// command codes the engine treats as no operation
	localparam logic [alie_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [alie_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam logic signed [alie_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [alie_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_DUPS, MIX_NOISE} mix_t;

	typedef struct {
		logic [alie_pkg::CMD_W-1:0]          cmd;
		logic [alie_pkg::POS_W-1:0]          position;
		logic signed [alie_pkg::DATA_W-1:0]  value;
	} list_cmd_t;

	typedef struct {
		logic [alie_pkg::ST_W-1:0]           status;
		logic [alie_pkg::OCNT_W-1:0]         new_count;
		logic [alie_pkg::OCNT_W-1:0]         removed_count;
		logic signed [alie_pkg::DATA_W-1:0]  read_value;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	alie_req_if req_ch ();
	alie_rsp_if rsp_ch ();

	array_list_insert_delete_engine #(
		.CAPACITY (LIST_CAP)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_cmd_t                          cmd_backlog[$];
	list_rsp_t                          pending_results[$];
	logic signed [alie_pkg::DATA_W-1:0] held_values[$];

	int  mismatches;
	int  cycle_count;
	int  items_queued;
	int  send_gap;
	int  stall_left;
	int  hold_left;
	bit  hold_request;
	bit  no_idle;
	bit  req_beat;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// shadow list update for one accepted command, returns the expected result
	function automatic list_rsp_t apply_list_cmd(list_cmd_t c);
		list_rsp_t r;
		int n;
		int p;
		int idx;
		int hits;
		n = held_values.size();
		p = int'(c.position);
		idx = 0;
		hits = 0;
		r.status = alie_pkg::ST_OK;
		r.removed_count = '0;
		r.read_value = '0;
		case (c.cmd)
			alie_pkg::CMD_INS_POS: begin
				if (n >= LIST_CAP)
					r.status = alie_pkg::ST_FULL;
				else if (p < 1 || p > n + 1)
					r.status = alie_pkg::ST_BADPOS;
				else
					held_values.insert(p - 1, c.value);
			end
			alie_pkg::CMD_INS_SORT: begin
				if (n >= LIST_CAP) begin
					r.status = alie_pkg::ST_FULL;
				end else begin
					while (idx < n && held_values[idx] < c.value)
						idx++;
					held_values.insert(idx, c.value);
				end
			end
			alie_pkg::CMD_DEL_POS: begin
				if (n == 0)
					r.status = alie_pkg::ST_EMPTY;
				else if (p < 1 || p > n)
					r.status = alie_pkg::ST_BADPOS;
				else begin
					held_values.delete(p - 1);
					r.removed_count = alie_pkg::OCNT_W'(1);
				end
			end
			alie_pkg::CMD_DEL_ONE: begin
				if (n == 0) begin
					r.status = alie_pkg::ST_EMPTY;
				end else begin
					while (idx < n && held_values[idx] != c.value)
						idx++;
					if (idx >= n) begin
						r.status = alie_pkg::ST_NOTFOUND;
					end else begin
						held_values.delete(idx);
						r.removed_count = alie_pkg::OCNT_W'(1);
					end
				end
			end
			alie_pkg::CMD_DEL_ALL: begin
				if (n == 0) begin
					r.status = alie_pkg::ST_EMPTY;
				end else begin
					for (idx = n - 1; idx >= 0; idx--) begin
						if (held_values[idx] == c.value) begin
							held_values.delete(idx);
							hits++;
						end
					end
					if (hits == 0)
						r.status = alie_pkg::ST_NOTFOUND;
					r.removed_count = alie_pkg::OCNT_W'(hits);
				end
			end
			alie_pkg::CMD_READ: begin
				if (n == 0)
					r.status = alie_pkg::ST_EMPTY;
				else if (p < 1 || p > n)
					r.status = alie_pkg::ST_BADPOS;
				else
					r.read_value = held_values[p - 1];
			end
			default: begin
			end
		endcase
		r.new_count = alie_pkg::OCNT_W'(held_values.size());
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [alie_pkg::CMD_W-1:0] pick_cmd(mix_t mix);
		int r;
		int t_ins;
		int t_sort;
		int t_delp;
		int t_del1;
		int t_dela;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW:   begin t_ins = 35; t_sort = 70; t_delp = 80; t_del1 = 85; t_dela = 88; end
			MIX_SHRINK: begin t_ins = 10; t_sort = 20; t_delp = 45; t_del1 = 65; t_dela = 80; end
			MIX_DUPS:   begin t_ins = 30; t_sort = 60; t_delp = 65; t_del1 = 72; t_dela = 90; end
			default:    begin t_ins = 20; t_sort = 40; t_delp = 55; t_del1 = 70; t_dela = 80; end
		endcase
		if (mix == MIX_NOISE)
			return alie_pkg::CMD_W'($urandom_range(0, 7));
		if (r < t_ins)
			return alie_pkg::CMD_INS_POS;
		if (r < t_sort)
			return alie_pkg::CMD_INS_SORT;
		if (r < t_delp)
			return alie_pkg::CMD_DEL_POS;
		if (r < t_del1)
			return alie_pkg::CMD_DEL_ONE;
		if (r < t_dela)
			return alie_pkg::CMD_DEL_ALL;
		return alie_pkg::CMD_READ;
	endfunction

	// values often from a small pool so that matches and duplicates are common
	function automatic logic signed [alie_pkg::DATA_W-1:0] pick_value(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		if (mix == MIX_NOISE)
			return $urandom;
		if (mix == MIX_DUPS)
			return (r < 70) ? -1 : 0;
		if (r < 40)
			return int'($urandom_range(0, 7)) - 4;
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// mostly a valid position for the current fill, sometimes anything
	function automatic logic [alie_pkg::POS_W-1:0] pick_position(int limit, mix_t mix);
		if (mix == MIX_NOISE || $urandom_range(0, 99) < 12)
			return alie_pkg::POS_W'($urandom_range(0, 31));
		if (limit < 1)
			return alie_pkg::POS_W'(1);
		return alie_pkg::POS_W'($urandom_range(1, limit));
	endfunction

	// keeps the backlog short so positions track the shadow list closely
	task automatic queue_cmd(logic [alie_pkg::CMD_W-1:0] op, logic [alie_pkg::POS_W-1:0] pos,
		logic signed [alie_pkg::DATA_W-1:0] val);
		list_cmd_t c;
		while (cmd_backlog.size() >= 3)
			@(posedge clk);
		c.cmd = op;
		c.position = pos;
		c.value = val;
		cmd_backlog.push_back(c);
		items_queued++;
	endtask

	task automatic wait_all_results();
		while (cmd_backlog.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string field, logic [alie_pkg::DATA_W-1:0] got,
		logic [alie_pkg::DATA_W-1:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, field, got, want);
		mismatches++;
	endtask

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// command beat accepted: update the shadow list and record the prediction
	always @(posedge clk) begin
		list_cmd_t c;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			c.cmd = req_ch.cmd;
			c.position = req_ch.position;
			c.value = req_ch.value;
			pending_results.push_back(apply_list_cmd(c));
			void'(cmd_backlog.pop_front());
			req_beat = 1'b1;
		end
	end

	// command driver
	always @(negedge clk) begin
		logic next_valid;
		if (arst_n) begin
			if (!(req_ch.valid && !req_beat)) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_backlog.size() > 0) begin
					req_ch.cmd <= cmd_backlog[0].cmd;
					req_ch.position <= cmd_backlog[0].position;
					req_ch.value <= cmd_backlog[0].value;
					next_valid = 1'b1;
					send_gap = no_idle ? 0 : pick_gap();
				end
				req_ch.valid <= next_valid;
			end
			req_beat = 1'b0;
		end else begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= '0;
			req_ch.position <= '0;
			req_ch.value <= '0;
		end
	end

	// result ready: random stalls, plus one long hold when asked
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (no_idle) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// result checker
	always @(posedge clk) begin
		list_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with none expected, status",
					alie_pkg::DATA_W'(rsp_ch.status), '0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", alie_pkg::DATA_W'(rsp_ch.status),
						alie_pkg::DATA_W'(want.status));
				if (rsp_ch.new_count !== want.new_count)
					report_mismatch("new_count", alie_pkg::DATA_W'(rsp_ch.new_count),
						alie_pkg::DATA_W'(want.new_count));
				if (rsp_ch.removed_count !== want.removed_count)
					report_mismatch("removed_count", alie_pkg::DATA_W'(rsp_ch.removed_count),
						alie_pkg::DATA_W'(want.removed_count));
				if (rsp_ch.read_value !== want.read_value)
					report_mismatch("read_value", rsp_ch.read_value, want.read_value);
			end
		end
	end

	// stimulus
	initial begin
		mix_t                       mix;
		logic [alie_pkg::CMD_W-1:0] op;
		int                         phase;
		int                         phase_len;
		int                         random_sent;
		int                         limit;
		mismatches = 0;
		cycle_count = 0;
		items_queued = 0;
		send_gap = 0;
		stall_left = 0;
		hold_left = 0;
		hold_request = 1'b0;
		no_idle = 1'b0;
		req_beat = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, bad positions, ordering, not found, spare codes
		queue_cmd(alie_pkg::CMD_READ, 5'd1, 0);
		queue_cmd(alie_pkg::CMD_DEL_POS, 5'd1, 0);
		queue_cmd(alie_pkg::CMD_DEL_ONE, 5'd0, 0);
		queue_cmd(alie_pkg::CMD_DEL_ALL, 5'd0, 0);
		queue_cmd(alie_pkg::CMD_INS_POS, 5'd0, 5);
		queue_cmd(alie_pkg::CMD_INS_POS, 5'd2, 5);
		queue_cmd(alie_pkg::CMD_INS_POS, 5'd1, VAL_MIN);
		queue_cmd(alie_pkg::CMD_INS_SORT, 5'd31, VAL_MAX);
		queue_cmd(alie_pkg::CMD_INS_SORT, 5'd0, 0);
		queue_cmd(alie_pkg::CMD_INS_SORT, 5'd0, VAL_MIN);
		queue_cmd(alie_pkg::CMD_INS_POS, 5'd5, 7);
		queue_cmd(alie_pkg::CMD_INS_POS, 5'd31, 9);
		queue_cmd(alie_pkg::CMD_READ, 5'd0, 0);
		queue_cmd(alie_pkg::CMD_READ, 5'd5, 0);
		queue_cmd(alie_pkg::CMD_READ, 5'd6, 0);
		queue_cmd(alie_pkg::CMD_DEL_ONE, 5'd0, 12345);
		queue_cmd(alie_pkg::CMD_DEL_ALL, 5'd0, 99);
		queue_cmd(alie_pkg::CMD_DEL_ALL, 5'd0, VAL_MIN);
		queue_cmd(alie_pkg::CMD_DEL_ONE, 5'd0, VAL_MAX);
		queue_cmd(alie_pkg::CMD_DEL_POS, 5'd3, 0);
		queue_cmd(alie_pkg::CMD_DEL_POS, 5'd0, 0);
		queue_cmd(CMD_SPARE_6, 5'd31, -1);
		queue_cmd(CMD_SPARE_7, 5'd1, VAL_MAX);
		queue_cmd(alie_pkg::CMD_DEL_POS, 5'd2, 0);
		queue_cmd(alie_pkg::CMD_READ, 5'd1, 0);
		wait_all_results();

		// random phases with shifting command mixes and fill levels
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: mix = MIX_GROW;
				3, 4:    mix = MIX_SHRINK;
				5, 6:    mix = MIX_EVEN;
				7, 8:    mix = MIX_DUPS;
				default: mix = MIX_NOISE;
			endcase
			if (phase == 0)
				mix = MIX_GROW;
			no_idle = ($urandom_range(0, 4) == 0);
			// receiver holds off while commands keep coming
			if (phase == 2) begin
				no_idle = 1'b0;
				hold_request = 1'b1;
			end
			// sender stops until the engine has answered everything
			if (phase % 6 == 5)
				wait_all_results();
			phase_len = $urandom_range(30, 80);
			for (int k = 0; k < phase_len; k++) begin
				op = pick_cmd(mix);
				limit = held_values.size();
				if (op == alie_pkg::CMD_INS_POS)
					limit++;
				queue_cmd(op, pick_position(limit, mix), pick_value(mix));
				random_sent++;
			end
			phase++;
		end

		wait_all_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/alie_pkg.sv
design/alie_if.sv
design/alie_cell.sv
design/array_list_insert_delete_engine.sv
test/tb_array_list_insert_delete_engine.sv
